/* hdl/sld_pkg.sv */
`timescale 1ns / 1ps

package sld_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_TOO_LONG = 2'd1,
        KIND_ZERO_LEN = 2'd2
    } kind_t;

    localparam logic [31:0] SYNC_WORD        = 32'h535A_3A20;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd1048576;
    localparam logic [1:0]  LEN_LAST_INDEX   = 2'd3;

endpackage

/* hdl/sync_length_deframer_core.sv */
`timescale 1ns / 1ps

// Output: a result word is registered and appears on m_* in the cycle after the input word that causes it.
// Throughput: one input word per cycle; the single result register stalls s_ready only
// when the next word is a payload or final length word while the held result is not taken.
// Reset: aresetn synchronous, active low; returns to sync hunting with a cleared window,
// no result pending, and max_length at 1048576.
module sync_length_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last
);

    sld_pkg::phase_t phase_reg, phase_next;
    logic [23:0] sync_window_reg, sync_window_next;
    logic [1:0]  length_index_reg, length_index_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] max_length_reg;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_out_kind_reg, m_out_kind_next;
    logic [7:0]  m_out_byte_reg, m_out_byte_next;
    logic        m_out_last_reg, m_out_last_next;

    logic        s_accept;
    logic        may_emit;
    logic        emit;
    logic [31:0] length_full;

    // words that can never produce a result pass even while the output holds
    always_comb begin
        case (phase_reg)
            sld_pkg::PH_LEN: may_emit = (length_index_reg == sld_pkg::LEN_LAST_INDEX);
            sld_pkg::PH_PAY: may_emit = 1'b1;
            default:         may_emit = 1'b0;
        endcase
    end

    assign s_ready  = !m_valid_reg || m_ready || !may_emit;
    assign s_accept = s_valid && s_ready;

    assign length_full = length_accum_reg
                       | ({24'd0, s_in_byte} << {length_index_reg, 3'b000});

    // next state
    always_comb begin
        phase_next        = phase_reg;
        sync_window_next  = sync_window_reg;
        length_index_next = length_index_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        if (s_accept) begin
            case (phase_reg)
                sld_pkg::PH_LEN: begin
                    if (length_index_reg != sld_pkg::LEN_LAST_INDEX) begin
                        length_accum_next = length_full;
                        length_index_next = length_index_reg + 2'd1;
                    end else if (length_full > max_length_reg || length_full == 32'd0) begin
                        phase_next        = sld_pkg::PH_HUNT;
                        sync_window_next  = 24'd0;
                        length_index_next = 2'd0;
                        length_accum_next = 32'd0;
                        bytes_left_next   = 32'd0;
                    end else begin
                        phase_next        = sld_pkg::PH_PAY;
                        length_index_next = 2'd0;
                        length_accum_next = length_full;
                        bytes_left_next   = length_full;
                    end
                end
                sld_pkg::PH_PAY: begin
                    bytes_left_next = bytes_left_reg - 32'd1;
                    if (bytes_left_reg == 32'd1) begin
                        phase_next        = sld_pkg::PH_HUNT;
                        sync_window_next  = 24'd0;
                        length_index_next = 2'd0;
                        length_accum_next = 32'd0;
                        bytes_left_next   = 32'd0;
                    end
                end
                default: begin
                    if ({sync_window_reg, s_in_byte} == sld_pkg::SYNC_WORD) begin
                        phase_next        = sld_pkg::PH_LEN;
                        sync_window_next  = 24'd0;
                        length_index_next = 2'd0;
                        length_accum_next = 32'd0;
                        bytes_left_next   = 32'd0;
                    end else begin
                        phase_next       = sld_pkg::PH_HUNT;
                        sync_window_next = {sync_window_reg[15:0], s_in_byte};
                    end
                end
            endcase
        end
    end

    // result word
    always_comb begin
        emit            = 1'b0;
        m_out_kind_next = sld_pkg::KIND_PAYLOAD;
        m_out_byte_next = 8'd0;
        m_out_last_next = 1'b0;
        case (phase_reg)
            sld_pkg::PH_LEN: begin
                if (length_index_reg == sld_pkg::LEN_LAST_INDEX) begin
                    if (length_full > max_length_reg) begin
                        emit            = 1'b1;
                        m_out_kind_next = sld_pkg::KIND_TOO_LONG;
                    end else if (length_full == 32'd0) begin
                        emit            = 1'b1;
                        m_out_kind_next = sld_pkg::KIND_ZERO_LEN;
                    end
                end
            end
            sld_pkg::PH_PAY: begin
                emit            = 1'b1;
                m_out_byte_next = s_in_byte;
                m_out_last_next = (bytes_left_reg == 32'd1);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (s_accept && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= sld_pkg::PH_HUNT;
            sync_window_reg  <= 24'd0;
            length_index_reg <= 2'd0;
            length_accum_reg <= 32'd0;
            bytes_left_reg   <= 32'd0;
            max_length_reg   <= sld_pkg::MAX_LENGTH_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            sync_window_reg  <= sync_window_next;
            length_index_reg <= length_index_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg   <= bytes_left_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_wr_en) begin
                max_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            m_out_kind_reg <= m_out_kind_next;
            m_out_byte_reg <= m_out_byte_next;
            m_out_last_reg <= m_out_last_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_kind = m_out_kind_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_out_last = m_out_last_reg;

`ifndef ASSERT_OFF
    a_len_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == sld_pkg::PH_LEN |-> sync_window_reg == 24'd0)
        else $error("window not cleared after sync match");

    a_pay_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == sld_pkg::PH_PAY |-> bytes_left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && phase_reg == sld_pkg::PH_PAY && bytes_left_reg == 32'd1
        |=> phase_reg == sld_pkg::PH_HUNT && m_valid && m_out_last)
        else $error("last payload word did not end frame");

    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind != sld_pkg::KIND_PAYLOAD |-> m_out_byte == 8'd0 && !m_out_last)
        else $error("status word carries payload bits");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        sld_pkg::kind_t kind;
        logic [7:0]     data;
        logic           last;
    } deframe_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_out_kind;
    logic [7:0]  m_out_byte;
    logic        m_out_last;

    // deframer prediction state
    logic [23:0]     hunt_window;
    sld_pkg::phase_t hunt_phase;
    logic [1:0]      len_count;
    logic [31:0]     len_value;
    logic [31:0]     payload_left;
    logic [31:0]     max_length_cfg;

    deframe_word_t pending_words[$];

    int errors;
    int words_sent;
    int payload_seen;
    int too_long_seen;
    int zero_len_seen;
    int limits_used;
    bit gaps_on;
    bit stalls_on;
    int stall_left;
    int stall_pick;

    sync_length_deframer_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_to_hunt();
        hunt_window  = '0;
        hunt_phase   = sld_pkg::PH_HUNT;
        len_count    = '0;
        len_value    = '0;
        payload_left = '0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        deframe_word_t w;
        w.kind = sld_pkg::KIND_PAYLOAD;
        w.data = 8'd0;
        w.last = 1'b0;
        if (hunt_phase == sld_pkg::PH_LEN) begin
            len_value = len_value | ({24'd0, b} << (8 * len_count));
            if (len_count != sld_pkg::LEN_LAST_INDEX) begin
                len_count = len_count + 2'd1;
            end else begin
                len_count = '0;
                if (len_value > max_length_cfg) begin
                    clear_to_hunt();
                    w.kind = sld_pkg::KIND_TOO_LONG;
                    pending_words.push_back(w);
                end else if (len_value == 32'd0) begin
                    clear_to_hunt();
                    w.kind = sld_pkg::KIND_ZERO_LEN;
                    pending_words.push_back(w);
                end else begin
                    payload_left = len_value;
                    hunt_phase   = sld_pkg::PH_PAY;
                end
            end
        end else if (hunt_phase == sld_pkg::PH_PAY) begin
            payload_left = payload_left - 32'd1;
            w.data = b;
            w.last = (payload_left == 32'd0);
            if (w.last) begin
                clear_to_hunt();
            end
            pending_words.push_back(w);
        end else if ({hunt_window, b} == sld_pkg::SYNC_WORD) begin
            clear_to_hunt();
            hunt_phase = sld_pkg::PH_LEN;
        end else begin
            hunt_window = {hunt_window[15:0], b};
        end
    endtask

    // receiver side: random backpressure, mostly short stalls
    always @(negedge aclk) begin
        if (!stalls_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 75) begin
                m_ready <= 1'b1;
            end else if (stall_pick < 95) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        deframe_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d byte %02h last %0b",
                                          m_out_kind, m_out_byte, m_out_last));
            end else begin
                want = pending_words.pop_front();
                if (m_out_kind !== want.kind || m_out_byte !== want.data
                        || m_out_last !== want.last) begin
                    report_mismatch($sformatf(
                        "kind %0d/%0d byte %02h/%02h last %0b/%0b (got/exp)",
                        m_out_kind, want.kind, m_out_byte, want.data,
                        m_out_last, want.last));
                end
                case (want.kind)
                    sld_pkg::KIND_PAYLOAD:  payload_seen++;
                    sld_pkg::KIND_TOO_LONG: too_long_seen++;
                    default:                zero_len_seen++;
                endcase
            end
        end
    end

    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = 0;
        if (gaps_on) begin
            gap = $urandom_range(0, 99);
            gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        end
        repeat (gap) @(negedge aclk) s_valid <= 1'b0;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        max_length_cfg = value;
        limits_used++;
    endtask

    task automatic send_frame(input logic [31:0] len, input bit with_prefix);
        if (with_prefix) begin
            send_word(sld_pkg::SYNC_WORD[31:24]);
        end
        for (int i = 3; i >= 0; i--) begin
            send_word(sld_pkg::SYNC_WORD[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++) begin
            send_word(len[8*i +: 8]);
        end
        while (hunt_phase == sld_pkg::PH_PAY) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(sld_pkg::SYNC_WORD[8*$urandom_range(0, 3) +: 8]);
            end else begin
                send_word($urandom_range(0, 255));
            end
        end
    endtask

    // an accidental sync in noise gets a zero length so the frame ends at once
    task automatic send_noise_byte(input logic [7:0] b);
        send_word(b);
        while (hunt_phase == sld_pkg::PH_LEN) send_word(8'h00);
    endtask

    function automatic logic [31:0] pick_len(input logic [31:0] lim);
        int r;
        logic [31:0] cap;
        r = $urandom_range(0, 99);
        cap = (lim > 32'd24) ? 32'd24 : lim;
        if (r < 10) begin
            return 32'd0;
        end
        if (r < 30 && lim != 32'hFFFF_FFFF) begin
            case ($urandom_range(0, 2))
                0: return lim + 32'd1;
                1: return 32'hFFFF_FFFF;
                default: return (lim < 32'hFFFF_0000) ? lim + 32'd1 + $urandom_range(0, 65535)
                                                     : lim + 32'd1;
            endcase
        end
        if (cap == 32'd0) begin
            return 32'd0;
        end
        if ($urandom_range(0, 4) == 0) begin
            return cap;
        end
        return $urandom_range(1, cap);
    endfunction

    task automatic run_traffic(input int n_words);
        int stop_at;
        int r;
        int n;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_frame(pick_len(max_length_cfg), 1'b0);
            end else if (r < 75) begin
                send_frame(pick_len(max_length_cfg), 1'b1);
            end else if (r < 85) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    send_noise_byte(sld_pkg::SYNC_WORD[8*(3-i) +: 8]);
                end
                send_noise_byte($urandom_range(0, 255));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 1)) begin
                        send_noise_byte(sld_pkg::SYNC_WORD[8*$urandom_range(0, 3) +: 8]);
                    end else begin
                        send_noise_byte($urandom_range(0, 255));
                    end
                end
            end
        end
    endtask

    task automatic test_directed();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_frame(32'd1, 1'b0);
        send_frame(32'd0, 1'b0);
        send_frame(sld_pkg::MAX_LENGTH_RESET + 32'd1, 1'b0);
    endtask

    task automatic test_reset_limit();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_traffic(64);
    endtask

    task automatic test_limit_extremes();
        write_max_length(32'd0);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_frame(32'd0, 1'b0);
        run_traffic(40);
        write_max_length(32'd1);
        gaps_on = 1'b1;
        run_traffic(64);
        write_max_length(32'hFFFF_FFFF);
        stalls_on = 1'b1;
        run_traffic(64);
    endtask

    task automatic test_limit_sweep();
        write_max_length(32'd5);
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        run_traffic(64);
        write_max_length(32'd24);
        gaps_on   = 1'b1;
        stalls_on = 1'b0;
        run_traffic(64);
        write_max_length($urandom_range(2, 20));
        stalls_on = 1'b1;
        run_traffic(64);
        write_max_length(32'h7FFF_FFFF);
        run_traffic(64);
    endtask

    task automatic test_drain_pause();
        write_max_length($urandom_range(6, 30));
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        run_traffic(40);
        drain_results();
        run_traffic(40);
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_in_byte   = '0;
        m_ready     = 1'b0;
        errors        = 0;
        words_sent    = 0;
        payload_seen  = 0;
        too_long_seen = 0;
        zero_len_seen = 0;
        limits_used   = 1;
        gaps_on       = 1'b0;
        stalls_on     = 1'b0;
        stall_left    = 0;
        max_length_cfg = sld_pkg::MAX_LENGTH_RESET;
        clear_to_hunt();
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_directed();
        test_reset_limit();
        test_limit_extremes();
        test_limit_sweep();
        test_drain_pause();

        drain_results();
        repeat (5) @(posedge aclk);
        $display("sent %0d words under %0d length limits", words_sent, limits_used);
        $display("checked %0d payload, %0d too-long, %0d zero-length results",
                 payload_seen, too_long_seen, zero_len_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sync_length_deframer_core.f */
hdl/sld_pkg.sv
hdl/sync_length_deframer_core.sv
tb/tb.sv
